// ===== rtl/tlbpt_pkg.sv =====
// tlbpt_pkg: sizes, types and transaction structs shared by the translator
// modules. No dependencies.
package tlbpt_pkg;

   localparam int TLB_ENTRIES   = 16;
   localparam int OFFSET_WIDTH  = 8;
   localparam int PAGE_WIDTH    = 8;

   localparam int ADDRESS_WIDTH = 16;
   localparam int DATA_WIDTH    = 8;
   localparam int COUNT_WIDTH   = 32;

   localparam int PAGE_COUNT    = 1 << PAGE_WIDTH;
   localparam int PAGE_BYTES    = 1 << OFFSET_WIDTH;
   localparam int PHYS_WIDTH    = PAGE_WIDTH + OFFSET_WIDTH;
   localparam int FRAME_DEPTH   = 1 << PHYS_WIDTH;
   localparam int BACKING_DEPTH = 1 << ADDRESS_WIDTH;
   localparam int FREE_WIDTH    = PAGE_WIDTH + 1;
   localparam int TLB_IDX_WIDTH = $clog2(TLB_ENTRIES);
   localparam int TLB_CNT_WIDTH = $clog2(TLB_ENTRIES + 1);

   // transaction codes on req_op
   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_LOAD      = 1'b1;

   typedef logic [PAGE_WIDTH-1:0]    page_type;
   typedef logic [TLB_IDX_WIDTH-1:0] tlb_idx_type;
   typedef logic [TLB_CNT_WIDTH-1:0] tlb_cnt_type;

   // lookup answer from the tlb
   typedef struct packed {
      logic        hit;
      tlb_idx_type pos;
      page_type    frame;
   } tlb_look_type;

   // reorder command to the tlb: drop an entry (hit position, or oldest when full) and append
   typedef struct packed {
      logic        valid;
      logic        hit;
      tlb_idx_type pos;
      page_type    page;
      page_type    frame;
   } tlb_update_type;

endpackage

// ===== rtl/tlbpt_ram.sv =====
// tlbpt_ram: generic simple dual-port ram, one write and one registered read.
// No dependencies.
module tlbpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ===== rtl/tlbpt_tlb.sv =====
// tlbpt_tlb: tlb held oldest to newest, parallel tag match, shift-down reorder.
// Depends on tlbpt_pkg.
module tlbpt_tlb (
   input  logic                      clock,
   input  logic                      reset,
   input  tlbpt_pkg::page_type       look_page,
   input  tlbpt_pkg::tlb_update_type upd,
   output tlbpt_pkg::tlb_look_type   look
);
   import tlbpt_pkg::*;

   page_type    tag_ff   [TLB_ENTRIES];
   page_type    tag_in   [TLB_ENTRIES];
   page_type    frame_ff [TLB_ENTRIES];
   page_type    frame_in [TLB_ENTRIES];
   tlb_cnt_type fill_ff;
   tlb_cnt_type fill_in;

   logic        rm;
   tlb_idx_type rm_pos;
   tlb_cnt_type fill_after;

   // lowest matching filled entry wins
   always_comb begin
      look = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (TLB_CNT_WIDTH'(i) < fill_ff && tag_ff[i] == look_page) begin
            look.hit   = 1'b1;
            look.pos   = TLB_IDX_WIDTH'(i);
            look.frame = frame_ff[i];
         end
      end
   end

   always_comb begin
      rm     = upd.valid && (upd.hit || fill_ff == TLB_CNT_WIDTH'(TLB_ENTRIES));
      rm_pos = upd.hit ? upd.pos : '0;
      fill_after = rm ? fill_ff - 1'b1 : fill_ff;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         tag_in[i]   = tag_ff[i];
         frame_in[i] = frame_ff[i];
      end
      // close the gap left by the dropped entry
      for (int i = 0; i < TLB_ENTRIES - 1; i++) begin
         if (rm && TLB_IDX_WIDTH'(i) >= rm_pos) begin
            tag_in[i]   = tag_ff[i + 1];
            frame_in[i] = frame_ff[i + 1];
         end
      end
      // append as newest
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (upd.valid && TLB_CNT_WIDTH'(i) == fill_after) begin
            tag_in[i]   = upd.page;
            frame_in[i] = upd.frame;
         end
      end
      fill_in = upd.valid ? fill_after + 1'b1 : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         tag_ff[i]   <= tag_in[i];
         frame_ff[i] <= frame_in[i];
      end
   end
endmodule

// ===== rtl/tlb_page_table_translator.sv =====
// tlb_page_table_translator: demand-paged translator top level, sequencer,
// page table, counters. Depends on tlbpt_pkg, tlbpt_ram and tlbpt_tlb.
//
// One transaction at a time: start is taken while busy is low, and exactly one
// result comes back on rsp_strobe for one cycle, which the receiver cannot
// stall. A load transaction writes one byte of the backing store, then
// returns its result. A translate that hits the tlb goes through search,
// frame memory read and result; a tlb miss that finds the page in the page
// table adds a page table ram read. A page fault adds a copy of the whole
// page, one byte at a time over the single byte-wide port pair between the
// backing store and frame memory. Unwritten frame bytes read back as
// whatever the ram holds.
module tlb_page_table_translator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_op,
   input  logic        [tlbpt_pkg::ADDRESS_WIDTH-1:0] req_address,
   input  logic signed [tlbpt_pkg::DATA_WIDTH-1:0]    req_data,
   output logic                                   rsp_strobe,
   output logic        [tlbpt_pkg::ADDRESS_WIDTH-1:0] rsp_phys_addr,
   output logic signed [tlbpt_pkg::DATA_WIDTH-1:0]    rsp_value,
   output logic                                   rsp_tlb_hit,
   output logic                                   rsp_page_fault,
   output logic        [tlbpt_pkg::COUNT_WIDTH-1:0]   rsp_hit_total,
   output logic        [tlbpt_pkg::COUNT_WIDTH-1:0]   rsp_fault_total
);
   import tlbpt_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_TABLE  = 3'd3;
   localparam logic [2:0] S_COPY   = 3'd4;
   localparam logic [2:0] S_READ   = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;

   // captured transaction
   logic                     op_ff;
   logic [ADDRESS_WIDTH-1:0] addr_ff;
   logic [DATA_WIDTH-1:0]    data_ff;

   // per-transaction outcome
   page_type frame_ff, frame_in;
   logic     hit_ff, hit_in;
   logic     fault_ff, fault_in;

   // persistent state
   logic [PAGE_COUNT-1:0]  page_valid_ff, page_valid_in;
   logic [FREE_WIDTH-1:0]  free_ff, free_in;
   logic [COUNT_WIDTH-1:0] hit_cnt_ff, hit_cnt_in;
   logic [COUNT_WIDTH-1:0] fault_cnt_ff, fault_cnt_in;

   // page copy pipeline: backing read, then frame write in the cycle after
   logic [OFFSET_WIDTH:0]   copy_cnt_ff, copy_cnt_in;
   logic                    copy_wr_ff, copy_wr_in;
   logic [OFFSET_WIDTH-1:0] copy_idx_ff;

   logic                    accept;
   page_type                page;
   logic [OFFSET_WIDTH-1:0] offset;
   logic                    copy_busy;

   tlb_look_type   look;
   tlb_update_type upd;

   // ram hookup
   logic                     bk_wr_en, bk_rd_en;
   logic [ADDRESS_WIDTH-1:0] bk_rd_addr;
   logic [DATA_WIDTH-1:0]    bk_rd_data;
   logic                     fr_rd_en;
   logic [DATA_WIDTH-1:0]    fr_rd_data;
   logic                     pt_wr_en, pt_rd_en;
   page_type                 pt_rd_data;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign page      = PAGE_WIDTH'(addr_ff >> OFFSET_WIDTH);
   assign offset    = OFFSET_WIDTH'(addr_ff);
   assign copy_busy = !copy_cnt_ff[OFFSET_WIDTH];

   tlbpt_tlb u_tlb (
      .clock     (clock),
      .reset     (reset),
      .look_page (page),
      .upd       (upd),
      .look      (look)
   );

   // backing store, written by load transactions, read by the page copy
   assign bk_wr_en   = (state_ff == S_LOAD);
   assign bk_rd_en   = (state_ff == S_COPY) && copy_busy;
   assign bk_rd_addr = ADDRESS_WIDTH'({page, copy_cnt_ff[OFFSET_WIDTH-1:0]});

   tlbpt_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (BACKING_DEPTH)
   ) u_backing (
      .clock   (clock),
      .wr_en   (bk_wr_en),
      .wr_addr (addr_ff),
      .wr_data (data_ff),
      .rd_en   (bk_rd_en),
      .rd_addr (bk_rd_addr),
      .rd_data (bk_rd_data)
   );

   // frame memory, filled by the page copy, read once per translate
   assign fr_rd_en = (state_ff == S_READ);

   tlbpt_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (FRAME_DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (copy_wr_ff),
      .wr_addr ({frame_ff, copy_idx_ff}),
      .wr_data (bk_rd_data),
      .rd_en   (fr_rd_en),
      .rd_addr ({frame_ff, offset}),
      .rd_data (fr_rd_data)
   );

   // page table frame numbers; valid bits live in flops
   assign pt_rd_en = (state_ff == S_SEARCH);
   assign pt_wr_en = (state_ff == S_TABLE) && !page_valid_ff[page];

   tlbpt_ram #(
      .WIDTH (PAGE_WIDTH),
      .DEPTH (PAGE_COUNT)
   ) u_page_table (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (page),
      .wr_data (PAGE_WIDTH'(free_ff)),
      .rd_en   (pt_rd_en),
      .rd_addr (page),
      .rd_data (pt_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      frame_in      = frame_ff;
      hit_in        = hit_ff;
      fault_in      = fault_ff;
      page_valid_in = page_valid_ff;
      free_in       = free_ff;
      hit_cnt_in    = hit_cnt_ff;
      fault_cnt_in  = fault_cnt_ff;
      copy_cnt_in   = copy_cnt_ff;
      copy_wr_in    = 1'b0;
      upd           = '0;
      upd.page      = page;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               hit_in   = 1'b0;
               fault_in = 1'b0;
               state_in = (req_op == OP_LOAD) ? S_LOAD : S_SEARCH;
            end
         end
         S_LOAD: begin
            state_in = S_RESP;
         end
         S_SEARCH: begin
            if (look.hit) begin
               // hit: move entry to newest
               hit_in    = 1'b1;
               frame_in  = look.frame;
               upd.valid = 1'b1;
               upd.hit   = 1'b1;
               upd.pos   = look.pos;
               upd.frame = look.frame;
               if (hit_cnt_ff != '1) begin
                  hit_cnt_in = hit_cnt_ff + 1'b1;
               end
               state_in = S_READ;
            end else begin
               state_in = S_TABLE;
            end
         end
         S_TABLE: begin
            upd.valid = 1'b1;
            if (page_valid_ff[page]) begin
               frame_in  = pt_rd_data;
               upd.frame = pt_rd_data;
               state_in  = S_READ;
            end else begin
               // page fault: claim next free frame and start the copy
               fault_in            = 1'b1;
               frame_in            = PAGE_WIDTH'(free_ff);
               upd.frame           = PAGE_WIDTH'(free_ff);
               page_valid_in[page] = 1'b1;
               if (free_ff != FREE_WIDTH'(PAGE_COUNT)) begin
                  free_in = free_ff + 1'b1;
               end
               if (fault_cnt_ff != '1) begin
                  fault_cnt_in = fault_cnt_ff + 1'b1;
               end
               copy_cnt_in = '0;
               state_in    = S_COPY;
            end
         end
         S_COPY: begin
            if (copy_busy) begin
               copy_wr_in  = 1'b1;
               copy_cnt_in = copy_cnt_ff + 1'b1;
            end else begin
               // last byte is written this cycle
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hit_ff        <= 1'b0;
         fault_ff      <= 1'b0;
         page_valid_ff <= '0;
         free_ff       <= '0;
         hit_cnt_ff    <= '0;
         fault_cnt_ff  <= '0;
         copy_cnt_ff   <= '0;
         copy_wr_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hit_ff        <= hit_in;
         fault_ff      <= fault_in;
         page_valid_ff <= page_valid_in;
         free_ff       <= free_in;
         hit_cnt_ff    <= hit_cnt_in;
         fault_cnt_ff  <= fault_cnt_in;
         copy_cnt_ff   <= copy_cnt_in;
         copy_wr_ff    <= copy_wr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         addr_ff <= req_address;
         data_ff <= DATA_WIDTH'(req_data);
      end
      frame_ff    <= frame_in;
      copy_idx_ff <= copy_cnt_ff[OFFSET_WIDTH-1:0];
   end

   // result: load transactions report only the counters
   assign rsp_strobe      = (state_ff == S_RESP);
   assign rsp_phys_addr   = (op_ff == OP_LOAD) ? '0 : {frame_ff, offset};
   assign rsp_value       = (op_ff == OP_LOAD) ? '0 : signed'(fr_rd_data);
   assign rsp_tlb_hit     = hit_ff;
   assign rsp_page_fault  = fault_ff;
   assign rsp_hit_total   = hit_cnt_ff;
   assign rsp_fault_total = fault_cnt_ff;

   // a result lasts exactly one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // a transaction never flags both a tlb hit and a fault
   a_hit_fault_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_tlb_hit && rsp_page_fault))
      else $error("hit and fault flagged together");

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");

   // frame writes happen only inside the page copy
   a_copy_window: assert property (@(posedge clock) disable iff (reset)
      copy_wr_ff |-> (state_ff == S_COPY))
      else $error("frame memory written outside page copy");

endmodule

// ===== tb/tb_tlb_page_table_translator.sv =====
// tb_tlb_page_table_translator: self-checking testbench for the demand-paged
// translator, with directed and random traffic checked against a predictor.
// Depends on tlbpt_pkg and tlb_page_table_translator.
`timescale 1ns / 1ps

module tb_tlb_page_table_translator;
   import tlbpt_pkg::*;

   localparam int CLOCK_HALF = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = OP_TRANSLATE;
   logic [ADDRESS_WIDTH-1:0]        req_address = '0;
   logic signed [DATA_WIDTH-1:0]    req_data = '0;
   logic        rsp_strobe;
   logic [ADDRESS_WIDTH-1:0]        rsp_phys_addr;
   logic signed [DATA_WIDTH-1:0]    rsp_value;
   logic        rsp_tlb_hit;
   logic        rsp_page_fault;
   logic [COUNT_WIDTH-1:0]          rsp_hit_total;
   logic [COUNT_WIDTH-1:0]          rsp_fault_total;

   tlb_page_table_translator u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_op               (req_op),
      .req_address          (req_address),
      .req_data             (req_data),
      .rsp_strobe           (rsp_strobe),
      .rsp_phys_addr        (rsp_phys_addr),
      .rsp_value            (rsp_value),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_fault_total      (rsp_fault_total)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // one expected result per accepted transaction
   typedef struct {
      logic [ADDRESS_WIDTH-1:0] phys_addr;
      logic [DATA_WIDTH-1:0]    value;
      logic                     tlb_hit;
      logic                     page_fault;
      logic [COUNT_WIDTH-1:0]   hit_total;
      logic [COUNT_WIDTH-1:0]   fault_total;
   } translation_type;

   translation_type expected_translations[$];
   int mismatch_count = 0;
   int idle_pct = 0;

   // predictor state: tlb in lru order, oldest at index 0
   page_type tlb_tag   [TLB_ENTRIES];
   page_type tlb_frame [TLB_ENTRIES];
   int       tlb_used = 0;
   // page table
   bit       pt_valid [PAGE_COUNT];
   page_type pt_frame [PAGE_COUNT];
   int       free_frame = 0;
   // frame memory and backing store, plus which backing bytes were ever loaded
   logic [DATA_WIDTH-1:0] frame_mem [BACKING_DEPTH];
   logic [DATA_WIDTH-1:0] store_mem [BACKING_DEPTH];
   bit       store_written [BACKING_DEPTH];
   logic [COUNT_WIDTH-1:0] hit_count = '0;
   logic [COUNT_WIDTH-1:0] fault_count = '0;

   // pages whose backing bytes are all loaded, safe to translate
   int       ready_pages[$];
   bit       page_listed [PAGE_COUNT];

   // shift newer entries down over the one at pos
   function automatic void tlb_drop(int pos);
      for (int i = pos; i + 1 < tlb_used; i++) begin
         tlb_tag[i]   = tlb_tag[i + 1];
         tlb_frame[i] = tlb_frame[i + 1];
      end
      tlb_used--;
   endfunction

   function automatic translation_type predict_translation(logic op,
         logic [ADDRESS_WIDTH-1:0] addr, logic [DATA_WIDTH-1:0] data);
      translation_type res;
      page_type        page;
      logic [OFFSET_WIDTH-1:0] offset;
      page_type        frame;
      int              pos;
      res = '{default: '0};
      if (op == OP_LOAD) begin
         store_mem[addr]     = data;
         store_written[addr] = 1'b1;
         res.hit_total   = hit_count;
         res.fault_total = fault_count;
         return res;
      end
      page   = addr[OFFSET_WIDTH +: PAGE_WIDTH];
      offset = addr[OFFSET_WIDTH-1:0];
      pos    = tlb_used;
      for (int i = 0; i < tlb_used; i++) begin
         if (tlb_tag[i] == page) begin
            pos = i;
            break;
         end
      end
      if (pos < tlb_used) begin
         // hit: pull the entry out, it goes back in as newest
         res.tlb_hit = 1'b1;
         frame = tlb_frame[pos];
         if (hit_count != '1) hit_count++;
         tlb_drop(pos);
      end else begin
         if (pt_valid[page]) begin
            frame = pt_frame[page];
         end else begin
            // page fault: copy the whole page into the next free frame
            res.page_fault = 1'b1;
            frame = page_type'(free_frame);
            for (int i = 0; i < PAGE_BYTES; i++)
               frame_mem[{frame, OFFSET_WIDTH'(i)}] = store_mem[{page, OFFSET_WIDTH'(i)}];
            pt_valid[page] = 1'b1;
            pt_frame[page] = frame;
            if (free_frame < PAGE_COUNT) free_frame++;
            if (fault_count != '1) fault_count++;
         end
         if (tlb_used >= TLB_ENTRIES) tlb_drop(0);
      end
      tlb_tag[tlb_used]   = page;
      tlb_frame[tlb_used] = frame;
      tlb_used++;
      res.phys_addr   = {frame, offset};
      res.value       = frame_mem[{frame, offset}];
      res.hit_total   = hit_count;
      res.fault_total = fault_count;
      return res;
   endfunction

   // drive one transaction, optionally after an idle gap, and wait for accept
   task automatic send_item(logic op, logic [ADDRESS_WIDTH-1:0] addr,
         logic [DATA_WIDTH-1:0] data);
      int gap;
      gap = 0;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_op      <= op;
      req_address <= addr;
      req_data    <= data;
      // busy read right after the edge is its value at that edge
      do @(posedge clock); while (busy);
      expected_translations.push_back(predict_translation(op, addr, data));
   endtask

   // hold off the sender until every outstanding result is back
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (expected_translations.size() != 0);
   endtask

   // load every not yet loaded byte of a page, then list it as translatable
   task automatic fill_page(int page);
      logic [ADDRESS_WIDTH-1:0] addr;
      for (int i = 0; i < PAGE_BYTES; i++) begin
         addr = {page_type'(page), OFFSET_WIDTH'(i)};
         if (!store_written[addr]) send_item(OP_LOAD, addr, DATA_WIDTH'($urandom));
      end
      if (!page_listed[page]) begin
         page_listed[page] = 1'b1;
         ready_pages.push_back(page);
      end
   endtask

   task automatic translate(int page, int offset);
      send_item(OP_TRANSLATE, {page_type'(page), OFFSET_WIDTH'(offset)},
                DATA_WIDTH'($urandom));
   endtask

   // field extremes on loads; counters read back as zero
   task automatic test_load_extremes();
      send_item(OP_LOAD, 16'h0000, 8'h80);
      send_item(OP_LOAD, 16'hffff, 8'h7f);
      send_item(OP_LOAD, 16'h8000, 8'hff);
      send_item(OP_LOAD, 16'h7fff, 8'h00);
      send_item(OP_LOAD, 16'h00ff, 8'h55);
      send_item(OP_LOAD, 16'hff00, 8'haa);
   endtask

   // first touch faults, second hits; a later load does not reach the frame
   task automatic test_fault_then_hit();
      fill_page(0);
      fill_page(PAGE_COUNT - 1);
      translate(0, 0);
      translate(0, PAGE_BYTES - 1);
      translate(PAGE_COUNT - 1, PAGE_BYTES - 1);
      translate(PAGE_COUNT - 1, 0);
      send_item(OP_TRANSLATE, 16'h0080, 8'h80);
      send_item(OP_LOAD, 16'h0000, 8'h11);
      translate(0, 0);
   endtask

   // overfill the tlb, then touch evicted pages (page table path) and a
   // middle entry (move to newest without a duplicate)
   task automatic test_tlb_eviction();
      for (int p = 1; p <= TLB_ENTRIES + 1; p++) fill_page(p);
      for (int p = 1; p <= TLB_ENTRIES + 1; p++) translate(p, $urandom_range(0, 255));
      translate(9, 3);
      translate(0, 1);
      translate(PAGE_COUNT - 1, 2);
      translate(9, 4);
      translate(2, 5);
      translate(9, 6);
   endtask

   // mostly translates of loaded pages biased toward a hot set, some
   // stray loads, and now and then a fresh page filled in
   task automatic test_random_traffic(int pct, int count);
      int r;
      int n;
      int idx;
      int page;
      idle_pct = pct;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            do page = $urandom_range(0, PAGE_COUNT - 1); while (page_listed[page]);
            fill_page(page);
            translate(page, $urandom_range(0, 255));
         end else if (r < 18) begin
            send_item(OP_LOAD, ADDRESS_WIDTH'($urandom), DATA_WIDTH'($urandom));
         end else begin
            n = ready_pages.size();
            if (n > 20 && $urandom_range(0, 99) < 70) idx = $urandom_range(n - 20, n - 1);
            else idx = $urandom_range(0, n - 1);
            translate(ready_pages[idx], $urandom_range(0, 255));
         end
      end
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // results cannot be stalled, so every strobe is taken as it comes
   always @(posedge clock) begin
      translation_type want;
      if (!reset && rsp_strobe) begin
         if (expected_translations.size() == 0) begin
            $error("result with no transaction outstanding");
            mismatch_count++;
         end else begin
            want = expected_translations.pop_front();
            compare_field("phys_addr", 32'(want.phys_addr), 32'(rsp_phys_addr));
            compare_field("value", 32'(want.value), 32'($unsigned(rsp_value)));
            compare_field("tlb_hit", 32'(want.tlb_hit), 32'(rsp_tlb_hit));
            compare_field("page_fault", 32'(want.page_fault), 32'(rsp_page_fault));
            compare_field("hit_total", want.hit_total, rsp_hit_total);
            compare_field("fault_total", want.fault_total, rsp_fault_total);
         end
      end
   end

   initial begin
      int guard;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 18;
      test_load_extremes();
      test_fault_then_hit();
      test_tlb_eviction();
      wait_drained();

      test_random_traffic(18, 135);
      wait_drained();
      test_random_traffic(62, 135);
      wait_drained();
      test_random_traffic(0, 135);

      // drain, then give a stray extra result time to show up
      start <= 1'b0;
      guard = 0;
      while (expected_translations.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_translations.size() != 0) begin
         $error("%0d results never arrived", expected_translations.size());
         mismatch_count++;
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #(700_000 * 2 * CLOCK_HALF);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tlbpt_pkg.sv
rtl/tlbpt_ram.sv
rtl/tlbpt_tlb.sv
rtl/tlb_page_table_translator.sv
tb/tb_tlb_page_table_translator.sv
